FILE: rtl/sacl_pkg.sv
package sacl_pkg;

    // Default sizes of the cache arrays.
    localparam int NUM_SETS_DEF   = 16;
    localparam int NUM_WAYS_DEF   = 4;
    localparam int ADDR_WIDTH_DEF = 16;

    // Widths of the access counter and of the fixed result fields.
    localparam int STAMP_W     = 32;
    localparam int SET_IDX_W   = 4;
    localparam int WAY_IDX_W   = 2;
    localparam int LINE_W      = 6;
    localparam int MEM_BLOCK_W = 16;

    // Configuration register widths and port widths.
    localparam int OFFSET_W   = 4;
    localparam int SETBITS_W  = 3;
    localparam int WAYS_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // The set number before reduction modulo the set count: set_bits is at most 7.
    localparam int SET_RAW_W = 7;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd3;

    // Replacement policies.
    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    // Register values after reset.
    localparam logic                 POLICY_RST      = POLICY_LRU;
    localparam logic [OFFSET_W-1:0]  OFFSET_BITS_RST = 4'd2;
    localparam logic [SETBITS_W-1:0] SET_BITS_RST    = 3'd2;
    localparam logic [WAYS_W-1:0]    WAYS_IN_USE_RST = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic look;
        logic scan;
        logic fill;
    } sacl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } sacl_status_t;

endpackage

FILE: rtl/sacl_ram.sv
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sacl_ctrl.sv
module sacl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  sacl_pkg::sacl_status_t status,
    output sacl_pkg::sacl_cmd_t    cmd,
    output logic                   busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FILL = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = start;
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = status.need_scan ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/sacl_datapath.sv
module sacl_datapath #(
    parameter int NUM_SETS   = sacl_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS   = sacl_pkg::NUM_WAYS_DEF,
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [ADDR_WIDTH-1:0]                  mem_address,
    input  sacl_pkg::sacl_cmd_t                    cmd,
    output sacl_pkg::sacl_status_t                 status,
    output logic                                   done,
    output logic                                   hit,
    output logic [sacl_pkg::SET_IDX_W-1:0]         set_index,
    output logic [sacl_pkg::WAY_IDX_W-1:0]         way_index,
    output logic [sacl_pkg::LINE_W-1:0]            line_number,
    output logic [sacl_pkg::MEM_BLOCK_W-1:0]       memory_block
);

    localparam int STAMP_W    = sacl_pkg::STAMP_W;
    localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WAYS_W     = sacl_pkg::WAYS_W;
    localparam int TAG_LO     = NUM_WAYS + WAY_W;
    localparam int STAMP_LO   = TAG_LO + NUM_WAYS * ADDR_WIDTH;
    localparam int ROW_W      = STAMP_LO + NUM_WAYS * STAMP_W;
    localparam int SET_RAW_W  = sacl_pkg::SET_RAW_W;
    localparam int SET_LUT_N  = 2 ** SET_RAW_W;
    localparam int FIFO_LUT_N = 2 ** (WAY_W + WAYS_W);
    localparam int LN_W       = SET_W + WAYS_W + WAY_W + 1;
    localparam int CMP_W      = WAY_W + WAYS_W;

    // Configuration registers.
    logic                                policy_reg;
    logic [sacl_pkg::OFFSET_W-1:0]       offset_reg;
    logic [sacl_pkg::SETBITS_W-1:0]      setbits_reg;
    logic [WAYS_W-1:0]                   ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= sacl_pkg::POLICY_RST;
            offset_reg  <= sacl_pkg::OFFSET_BITS_RST;
            setbits_reg <= sacl_pkg::SET_BITS_RST;
            ways_reg    <= sacl_pkg::WAYS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sacl_pkg::REG_POLICY:      policy_reg  <= cfg_data[0];
                sacl_pkg::REG_OFFSET_BITS: offset_reg  <= cfg_data[sacl_pkg::OFFSET_W-1:0];
                sacl_pkg::REG_SET_BITS:    setbits_reg <= cfg_data[sacl_pkg::SETBITS_W-1:0];
                sacl_pkg::REG_WAYS_IN_USE: ways_reg    <= cfg_data[WAYS_W-1:0];
                default:                   policy_reg  <= policy_reg;
            endcase
        end
    end

    // Effective associativity: zero counts as one, large values saturate.
    logic [WAYS_W-1:0] eff_ways;

    always_comb
    begin
        if (ways_reg == '0)
        begin
            eff_ways = WAYS_W'(1);
        end
        else if (int'(ways_reg) > NUM_WAYS)
        begin
            eff_ways = WAYS_W'(NUM_WAYS);
        end
        else
        begin
            eff_ways = ways_reg;
        end
    end

    // Constant tables: set number modulo the set count, and FIFO pointer
    // modulo the ways in use.
    logic [SET_W-1:0] set_lut  [SET_LUT_N];
    logic [WAY_W-1:0] fifo_lut [FIFO_LUT_N];

    for (genvar g = 0; g < SET_LUT_N; g++)
    begin : g_set_lut
        localparam int SET_MOD = g % NUM_SETS;
        assign set_lut[g] = SET_W'(SET_MOD);
    end

    for (genvar f = 0; f < 2 ** WAY_W; f++)
    begin : g_fifo_f
        for (genvar w = 0; w < 2 ** WAYS_W; w++)
        begin : g_fifo_w
            localparam int FIFO_MOD = (w == 0) ? 0 : (f % ((w == 0) ? 1 : w));
            assign fifo_lut[f * (2 ** WAYS_W) + w] = WAY_W'(FIFO_MOD);
        end
    end

    // Address split at the input transaction.
    logic [ADDR_WIDTH-1:0] blk_in;
    logic [SET_RAW_W-1:0]  set_mask;
    logic [SET_RAW_W-1:0]  set_raw;
    logic [SET_W-1:0]      set_in;

    assign blk_in   = mem_address >> offset_reg;
    assign set_mask = SET_RAW_W'((8'd1 << setbits_reg) - 8'd1);
    assign set_raw  = blk_in[SET_RAW_W-1:0] & set_mask;
    assign set_in   = set_lut[set_raw];

    logic [ADDR_WIDTH-1:0] block_reg;
    logic [SET_W-1:0]      set_reg;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [STAMP_W-1:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            block_reg <= blk_in;
            set_reg   <= set_in;
            stamp_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.accept && (count_reg != '1))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // One RAM row per set: stamps, tags, FIFO pointer and valid bits.
    logic             wr_en;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] wr_row;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (set_reg),
        .wdata (wr_row),
        .re    (cmd.accept),
        .raddr (set_in),
        .rdata (rd_row)
    );

    // A set that has never been written reads as empty with its pointer at zero.
    logic [NUM_SETS-1:0] touched_reg;

    logic [NUM_WAYS-1:0]               valid_w;
    logic [NUM_WAYS-1:0][ADDR_WIDTH-1:0] tags_w;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]  stamps_w;
    logic [WAY_W-1:0]                  fifo_w;

    always_comb
    begin
        for (int j = 0; j < NUM_WAYS; j++)
        begin
            valid_w[j]  = rd_row[j] & touched_reg[set_reg];
            tags_w[j]   = rd_row[TAG_LO + j * ADDR_WIDTH +: ADDR_WIDTH];
            stamps_w[j] = rd_row[STAMP_LO + j * STAMP_W +: STAMP_W];
        end
        fifo_w = touched_reg[set_reg] ? rd_row[NUM_WAYS +: WAY_W] : '0;
    end

    // Parallel tag compare and empty search; the lowest way wins.
    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic             empty_any;
    logic [WAY_W-1:0] empty_way;

    always_comb
    begin
        hit_any   = 1'b0;
        hit_way   = '0;
        empty_any = 1'b0;
        empty_way = '0;
        for (int j = NUM_WAYS - 1; j >= 0; j--)
        begin
            if (j < int'(eff_ways))
            begin
                if (valid_w[j] && (tags_w[j] == block_reg))
                begin
                    hit_any = 1'b1;
                    hit_way = WAY_W'(j);
                end
                if (!valid_w[j])
                begin
                    empty_any = 1'b1;
                    empty_way = WAY_W'(j);
                end
            end
        end
    end

    logic [WAY_W-1:0] fifo_way;
    logic [WAY_W-1:0] fifo_adv;
    logic             fifo_replace;
    logic             need_scan;
    logic [WAY_W-1:0] look_way;

    assign fifo_way = fifo_lut[{fifo_w, eff_ways}];
    assign fifo_adv = (CMP_W'(fifo_way) + CMP_W'(1) == CMP_W'(eff_ways)) ?
                      '0 : WAY_W'(fifo_way + 1'b1);

    assign need_scan    = !hit_any && !empty_any && (policy_reg == sacl_pkg::POLICY_LRU);
    assign fifo_replace = cmd.look && !hit_any && !empty_any &&
                          (policy_reg == sacl_pkg::POLICY_FIFO);
    assign look_way     = hit_any ? hit_way : (empty_any ? empty_way : fifo_way);

    // LRU victim scan, one way per cycle over the row held at the RAM output.
    logic [WAY_W-1:0]   scan_j_reg;
    logic [STAMP_W-1:0] smallest_reg;
    logic [WAY_W-1:0]   victim_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.look)
        begin
            scan_j_reg   <= '0;
            smallest_reg <= stamp_reg;
            victim_reg   <= '0;
        end
        else if (cmd.scan)
        begin
            if (stamps_w[scan_j_reg] < smallest_reg)
            begin
                smallest_reg <= stamps_w[scan_j_reg];
                victim_reg   <= scan_j_reg;
            end
            scan_j_reg <= WAY_W'(scan_j_reg + 1'b1);
        end
    end

    assign status.need_scan = need_scan;
    assign status.scan_last = (CMP_W'(scan_j_reg) == CMP_W'(eff_ways) - CMP_W'(1));

    // Write-back of the chosen way and the result.
    logic             finish;
    logic [WAY_W-1:0] fin_way;
    logic             fin_hit;
    logic             do_stamp;

    assign finish   = (cmd.look && !need_scan) || cmd.fill;
    assign fin_way  = cmd.fill ? victim_reg : look_way;
    assign fin_hit  = cmd.fill ? 1'b0 : hit_any;
    assign do_stamp = !fin_hit || (policy_reg == sacl_pkg::POLICY_LRU);
    assign wr_en    = finish;

    always_comb
    begin
        wr_row = rd_row;
        for (int j = 0; j < NUM_WAYS; j++)
        begin
            wr_row[j] = valid_w[j] | (WAY_W'(j) == fin_way);
            if (WAY_W'(j) == fin_way)
            begin
                wr_row[TAG_LO + j * ADDR_WIDTH +: ADDR_WIDTH] = block_reg;
                if (do_stamp)
                begin
                    wr_row[STAMP_LO + j * STAMP_W +: STAMP_W] = stamp_reg;
                end
            end
        end
        wr_row[NUM_WAYS +: WAY_W] = fifo_replace ? fifo_adv : fifo_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg <= '0;
            done        <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                touched_reg[set_reg] <= 1'b1;
            end
            done <= finish;
        end
    end

    logic [LN_W-1:0] line_calc;

    assign line_calc = LN_W'(set_reg) * LN_W'(eff_ways) + LN_W'(fin_way);

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            hit          <= fin_hit;
            set_index    <= sacl_pkg::SET_IDX_W'(set_reg);
            way_index    <= sacl_pkg::WAY_IDX_W'(fin_way);
            line_number  <= sacl_pkg::LINE_W'(line_calc);
            memory_block <= sacl_pkg::MEM_BLOCK_W'(block_reg);
        end
    end

endmodule

FILE: rtl/set_assoc_cache_lookup.sv
// Channel        Signals                                    Handshake
// command        start, mem_address                         start && !busy
// result         done, hit, set_index, way_index,           done, one cycle
//                line_number, memory_block
// configuration  cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// A hit, a fill of an empty way or a FIFO replacement finishes in the look-up
// state, and the next transaction can be accepted in the cycle that shows the
// result. An LRU replacement goes on through the stamp search, which visits one
// way of the set per cycle, and then a fill state before the result strobe.
// Reset is asynchronous and needs no clearing pass: a per-set flag marks sets
// never written, which read as empty. The receiver cannot stall the result.
module set_assoc_cache_lookup #(
    parameter int NUM_SETS   = sacl_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS   = sacl_pkg::NUM_WAYS_DEF,
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ADDR_WIDTH-1:0]              mem_address,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               done,
    output logic                               hit,
    output logic [sacl_pkg::SET_IDX_W-1:0]     set_index,
    output logic [sacl_pkg::WAY_IDX_W-1:0]     way_index,
    output logic [sacl_pkg::LINE_W-1:0]        line_number,
    output logic [sacl_pkg::MEM_BLOCK_W-1:0]   memory_block
);

    sacl_pkg::sacl_cmd_t    cmd;
    sacl_pkg::sacl_status_t status;

    // The user makes writes only while idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sacl_datapath #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mem_address  (mem_address),
        .cmd          (cmd),
        .status       (status),
        .done         (done),
        .hit          (hit),
        .set_index    (set_index),
        .way_index    (way_index),
        .line_number  (line_number),
        .memory_block (memory_block)
    );

endmodule

FILE: rtl/sacl_checker.sv
module sacl_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result is shown only once the block has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Each transaction gives a single-cycle result strobe.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on consecutive cycles");

    // An accepted transaction occupies the block and cannot finish at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not occupy the block");

    // A result follows a cycle of work.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

endmodule

bind set_assoc_cache_lookup sacl_checker u_sacl_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
